/* rtl/core/tpdp_pkg.sv */
// Shared types and constants of the trapezoid profile drive controller.
// Used by the top level, the divider and the port checker; no dependencies.
`default_nettype none

package tpdp_pkg;

   localparam int CNT_W = 32;   // encoder count width
   localparam int TFRAC = 16;   // fraction bits of time values

   localparam logic [7:0] ORIENT_KP = 8'd77;   // 0.3 in Q0.8
   localparam logic [9:0] PWM_MAX   = 10'd1023;

   typedef enum logic [2:0] {
      REG_CRUISE_SPEED = 3'd0,
      REG_ACCEL        = 3'd1,
      REG_KP_DIST      = 3'd2,
      REG_KI_DIST      = 3'd3,
      REG_KD_DIST      = 3'd4,
      REG_KI_TURN      = 3'd5,
      REG_KD_TURN      = 3'd6,
      REG_MIN_PWM      = 3'd7
   } reg_index_type;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic signed [CNT_W-1:0] length_count;
      logic signed [CNT_W-1:0] left_count;
      logic signed [CNT_W-1:0] right_count;
      logic signed [15:0]      left_speed;
      logic signed [15:0]      right_speed;
      logic [15:0]             time_step;
      logic signed [31:0]      target_length;
      logic signed [31:0]      target_angle;
   } req_type;

   typedef struct packed {
      logic [9:0] left_pwm;
      logic [9:0] right_pwm;
      logic       left_dir;
      logic       right_dir;
   } rsp_type;

   // divider command: quotient of a signed dividend by a positive divisor
   typedef struct packed {
      logic               start;
      logic signed [63:0] dividend;
      logic [30:0]        divisor;
   } div_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tpdp_div.sv */
// Restoring divider, one quotient bit per cycle, saturating 32-bit signed quotient.
// Depends on tpdp_pkg for the command type.
`default_nettype none

module tpdp_div import tpdp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_cmd_type        div_cmd,
   output logic               div_busy,
   output logic signed [31:0] div_quo
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] rem_ff, rem_in;
   logic [30:0] work_ff, work_in;
   logic [30:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;

   logic [63:0] mag;
   logic [31:0] trial;
   logic [31:0] diff;
   logic        ge;

   assign mag   = div_cmd.dividend[63] ? 64'(-div_cmd.dividend) : 64'(div_cmd.dividend);
   assign trial = {rem_ff, work_ff[30]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (div_cmd.start) begin
         // quotient of 2^31 or more saturates at once
         ovf_in  = mag[63:31] >= {2'b00, div_cmd.divisor};
         neg_in  = div_cmd.dividend[63];
         dsr_in  = div_cmd.divisor;
         rem_in  = mag[61:31];
         work_in = mag[30:0];
         cnt_in  = 5'd30;
         busy_in = !(mag[63:31] >= {2'b00, div_cmd.divisor});
      end else if (busy_ff) begin
         rem_in  = ge ? diff[30:0] : trial[30:0];
         work_in = {work_ff[29:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

   assign div_busy = busy_ff;

   always_comb begin
      if (ovf_ff) begin
         div_quo = neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (neg_ff) begin
         div_quo = -$signed({1'b0, work_ff});
      end else begin
         div_quo = $signed({1'b0, work_ff});
      end
   end

endmodule

`default_nettype wire

/* rtl/core/trapezoid_profile_diff_drive_pi_unit.sv */
// Top level: trapezoid length profile, distance and orientation PI, wheel PWM.
// Depends on tpdp_pkg and tpdp_div.
//
//   port group  direction  handshake        content
//   req_        in         valid / ready    req_type: start move or control tick
//   rsp_        out        valid / ready    rsp_type: wheel PWM and direction
//   csr_        in         write enable     register index and 16-bit data
//
// A start request and a tick both use the 31-step divider (acceleration distance,
// angle setpoint) and the one shared 33x33 multiplier, which forms 7 to 11 products
// per tick in turn, depending on the profile phase.
// Reset is synchronous; it clears the move state and integrators and sets the registers to their reset values.
// A finished result waits in the output register while the next request is taken;
// a tick stalls in its last step only while an earlier result is still waiting.
`default_nettype none

module trapezoid_profile_diff_drive_pi_unit import tpdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [25:0] {
      S_IDLE  = 26'd1 << 0,
      S_SQ    = 26'd1 << 1,
      S_SDIV  = 26'd1 << 2,
      S_SWAIT = 26'd1 << 3,
      S_PHASE = 26'd1 << 4,
      S_D0    = 26'd1 << 5,
      S_C1    = 26'd1 << 6,
      S_D1    = 26'd1 << 7,
      S_A0    = 26'd1 << 8,
      S_A1    = 26'd1 << 9,
      S_A2    = 26'd1 << 10,
      S_A3    = 26'd1 << 11,
      S_TERM  = 26'd1 << 12,
      S_D2    = 26'd1 << 13,
      S_XC    = 26'd1 << 14,
      S_E1    = 26'd1 << 15,
      S_E2    = 26'd1 << 16,
      S_E3    = 26'd1 << 17,
      S_E4    = 26'd1 << 18,
      S_E5    = 26'd1 << 19,
      S_DWAIT = 26'd1 << 20,
      S_O1    = 26'd1 << 21,
      S_O2    = 26'd1 << 22,
      S_O3    = 26'd1 << 23,
      S_O4    = 26'd1 << 24,
      S_OUT   = 26'd1 << 25
   } state_type;

   typedef enum logic [1:0] {
      PH_ACCEL  = 2'd0,
      PH_CRUISE = 2'd1,
      PH_DECEL  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0]        cruise_speed;
      logic [15:0]        accel;
      logic signed [15:0] kp_dist;
      logic signed [15:0] ki_dist;
      logic signed [15:0] kd_dist;
      logic signed [15:0] ki_turn;
      logic signed [15:0] kd_turn;
      logic [9:0]         min_pwm;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        elapsed;
      logic signed [31:0] base_len;
      logic signed [31:0] base_left;
      logic signed [31:0] base_right;
      logic signed [31:0] abs_target;
      logic signed [31:0] angle_target;
      logic               move_sign;
      logic signed [31:0] accel_dist;
      logic signed [32:0] decel_start;
      logic signed [31:0] profile_pos;
      logic [31:0]        accel_end_time;
      logic [31:0]        cruise_end_time;
      logic signed [31:0] accel_end_pos;
      logic signed [31:0] cruise_end_pos;
      logic signed [31:0] dist_int;
      logic signed [31:0] orient_int;
   } move_type;

   typedef struct packed {
      logic [9:0] pwm;
      logic       pos;
      logic       neg;
   } wheel_type;

   localparam cfg_type CFG_RESET = '{
      cruise_speed: 16'd1000, accel: 16'd1000, kp_dist: 16'sd256,
      ki_dist: 16'sd0, kd_dist: 16'sd0, ki_turn: 16'sd0, kd_turn: 16'sd0,
      min_pwm: 10'd0
   };
   localparam logic [63:0] SAT_CAP = 64'd1 << 62;

   function automatic wheel_type wheel(input logic signed [52:0] cmd,
                                       input logic [9:0] min_pwm);
      logic [52:0] mag;
      logic        dead;
      wheel_type   w;
      mag   = cmd[52] ? 53'(-cmd) : 53'(cmd);
      dead  = mag < {35'd0, min_pwm, 8'd0};
      if (dead) begin
         w.pwm = 10'd0;
      end else if (mag[52:8] > {35'd0, PWM_MAX}) begin
         w.pwm = PWM_MAX;
      end else begin
         w.pwm = mag[17:8];
      end
      w.pos = !dead && !cmd[52] && (cmd != 53'sd0);
      w.neg = !dead && cmd[52];
      return w;
   endfunction

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   move_type  mv_ff, mv_in;
   phase_type phase_ff, phase_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [31:0]        dt_ff, dt_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [15:0]        hi_ff, hi_in;
   logic signed [51:0] acc_ff, acc_in;
   logic [47:0]        msdt_ff, msdt_in;
   logic [62:0]        term_ff, term_in;
   logic signed [63:0] q_ff, q_in;
   logic signed [31:0] xc_ff, xc_in;
   logic signed [32:0] xs_ff, xs_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] orient_ff, orient_in;
   logic signed [31:0] oerr_ff, oerr_in;
   logic signed [51:0] cdist_ff, cdist_in;
   logic signed [51:0] corient_ff, corient_in;

   logic signed [32:0] mul_a, mul_b;
   div_cmd_type        div_cmd;
   logic               div_busy;
   logic signed [31:0] div_quo;

   logic               accept;
   logic [15:0]        accel_eff;
   logic [32:0]        tsum;
   logic signed [31:0] tl;
   logic signed [31:0] len_d, inc_l, inc_r;
   logic signed [16:0] spd_sum, robot_spd, spd_diff;
   logic [31:0]        sq_src;
   logic [63:0]        full;
   logic signed [31:0] accel_pos, cruise_pos, decel_pos;
   logic signed [63:0] cruise_sum, decel_q, decel_t;
   logic [63:0]        q_mag;
   logic signed [32:0] xs_w;
   logic signed [31:0] theta;
   logic signed [52:0] cmd_l, cmd_r;
   wheel_type          wl, wr;

   tpdp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_busy (div_busy),
      .div_quo  (div_quo)
   );

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign accel_eff = (cfg_ff.accel == 16'd0) ? 16'd1 : cfg_ff.accel;
   assign tsum      = {1'b0, mv_ff.elapsed} + {17'd0, req_data.time_step};
   assign tl        = req_data.target_length;

   assign len_d     = req_ff.length_count - mv_ff.base_len;
   assign inc_l     = req_ff.left_count - mv_ff.base_left;
   assign inc_r     = req_ff.right_count - mv_ff.base_right;
   assign spd_sum   = 17'(req_ff.left_speed) + 17'(req_ff.right_speed);
   assign robot_spd = (spd_sum + $signed({16'd0, spd_sum[16]})) >>> 1;
   assign spd_diff  = 17'(req_ff.right_speed) - 17'(req_ff.left_speed);

   assign sq_src    = (phase_ff == PH_ACCEL) ? mv_ff.elapsed : dt_ff;
   assign full      = {prod_ff[31:0], 32'd0} + {16'd0, acc_ff[47:0]};

   assign accel_pos  = (|term_ff[62:TFRAC+32]) ? 32'sh7fff_ffff
                                               : $signed({1'b0, term_ff[TFRAC+31:TFRAC+1]});
   assign cruise_sum = $signed({32'd0, prod_ff[TFRAC+31:TFRAC]}) + 64'(mv_ff.accel_end_pos);
   assign cruise_pos = sat32(cruise_sum);
   assign decel_q    = $signed({{16{mv_ff.cruise_end_pos[31]}}, mv_ff.cruise_end_pos, 16'd0})
                     + $signed({16'd0, msdt_ff}) - $signed({2'b00, term_ff[62:1]});
   // truncate toward zero
   assign q_mag      = q_ff[63] ? 64'(-q_ff) : 64'(q_ff);
   assign decel_t    = q_ff[63] ? -$signed(q_mag >> TFRAC) : $signed(q_mag >> TFRAC);
   assign decel_pos  = sat32(decel_t);

   assign xs_w  = mv_ff.move_sign ? 33'(xc_ff) : -33'(xc_ff);
   assign theta = (mv_ff.abs_target == 32'sd0) ? 32'sd0 : div_quo;

   assign cmd_l = 53'(cdist_ff) - 53'(corient_ff);
   assign cmd_r = 53'(cdist_ff) + 53'(corient_ff);
   assign wl    = wheel(cmd_l, cfg_ff.min_pwm);
   assign wr    = wheel(cmd_r, cfg_ff.min_pwm);

   assign prod_in = mul_a * mul_b;

   // shared multiplier operand select
   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (state_ff)
         S_SQ: begin
            mul_a = $signed({17'd0, cfg_ff.cruise_speed});
            mul_b = $signed({17'd0, cfg_ff.cruise_speed});
         end
         S_A0: begin
            mul_a = $signed({1'b0, sq_src});
            mul_b = $signed({1'b0, sq_src});
         end
         S_A1: begin
            mul_a = $signed({1'b0, prod_ff[TFRAC+31:TFRAC]});
            mul_b = $signed({17'd0, accel_eff});
         end
         S_A2: begin
            mul_a = $signed({17'd0, hi_ff});
            mul_b = $signed({17'd0, accel_eff});
         end
         S_D0: begin
            mul_a = $signed({17'd0, cfg_ff.cruise_speed});
            mul_b = $signed({1'b0, dt_ff});
         end
         S_E1: begin
            mul_a = 33'(mv_ff.angle_target);
            mul_b = xs_ff;
         end
         S_E2: begin
            mul_a = 33'(err_ff);
            mul_b = 33'(cfg_ff.kp_dist);
         end
         S_E3: begin
            mul_a = 33'(mv_ff.dist_int);
            mul_b = 33'(cfg_ff.ki_dist);
         end
         S_E4: begin
            mul_a = 33'(cfg_ff.kd_dist);
            mul_b = 33'(robot_spd);
         end
         S_O1: begin
            mul_a = 33'(oerr_ff);
            mul_b = $signed({25'd0, ORIENT_KP});
         end
         S_O2: begin
            mul_a = 33'(mv_ff.orient_int);
            mul_b = 33'(cfg_ff.ki_turn);
         end
         S_O3: begin
            mul_a = 33'(cfg_ff.kd_turn);
            mul_b = 33'(spd_diff);
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      mv_in        = mv_ff;
      phase_in     = phase_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dt_in        = dt_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      msdt_in      = msdt_ff;
      term_in      = term_ff;
      q_in         = q_ff;
      xc_in        = xc_ff;
      xs_in        = xs_ff;
      err_in       = err_ff;
      orient_in    = orient_ff;
      oerr_in      = oerr_ff;
      cdist_in     = cdist_ff;
      corient_in   = corient_ff;
      div_cmd      = '0;

      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_CRUISE_SPEED: cfg_in.cruise_speed = csr_wdata;
            REG_ACCEL:        cfg_in.accel        = csr_wdata;
            REG_KP_DIST:      cfg_in.kp_dist      = $signed(csr_wdata);
            REG_KI_DIST:      cfg_in.ki_dist      = $signed(csr_wdata);
            REG_KD_DIST:      cfg_in.kd_dist      = $signed(csr_wdata);
            REG_KI_TURN:      cfg_in.ki_turn      = $signed(csr_wdata);
            REG_KD_TURN:      cfg_in.kd_turn      = $signed(csr_wdata);
            REG_MIN_PWM:      cfg_in.min_pwm      = csr_wdata[9:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.mode == MODE_START) begin
                  mv_in.base_len     = req_data.length_count;
                  mv_in.base_left    = req_data.left_count;
                  mv_in.base_right   = req_data.right_count;
                  mv_in.angle_target = req_data.target_angle;
                  mv_in.move_sign    = tl > 32'sd0;
                  if (tl == 32'sh8000_0000) begin
                     mv_in.abs_target = 32'sh7fff_ffff;
                  end else if (tl < 32'sd0) begin
                     mv_in.abs_target = -tl;
                  end else begin
                     mv_in.abs_target = tl;
                  end
                  mv_in.elapsed         = 32'd0;
                  mv_in.profile_pos     = 32'sd0;
                  mv_in.accel_end_time  = 32'd0;
                  mv_in.cruise_end_time = 32'd0;
                  mv_in.accel_end_pos   = 32'sd0;
                  mv_in.cruise_end_pos  = 32'sd0;
                  state_in = S_SQ;
               end else begin
                  mv_in.elapsed = tsum[32] ? 32'hffff_ffff : tsum[31:0];
                  state_in = S_PHASE;
               end
            end
         end
         S_SQ: state_in = S_SDIV;
         S_SDIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = $signed({32'd0, prod_ff[31:0]});
            div_cmd.divisor  = {14'd0, accel_eff, 1'b0};
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (!div_busy) begin
               mv_in.accel_dist  = div_quo;
               mv_in.decel_start = 33'(mv_ff.abs_target) - 33'(div_quo);
               state_in = S_IDLE;
            end
         end
         S_PHASE: begin
            if (mv_ff.profile_pos < mv_ff.accel_dist) begin
               phase_in = PH_ACCEL;
               state_in = S_A0;
            end else if (33'(mv_ff.profile_pos) < mv_ff.decel_start) begin
               phase_in = PH_CRUISE;
               dt_in = (mv_ff.elapsed > mv_ff.accel_end_time)
                     ? mv_ff.elapsed - mv_ff.accel_end_time : 32'd0;
               state_in = S_D0;
            end else if (mv_ff.profile_pos >= mv_ff.abs_target) begin
               xc_in    = mv_ff.abs_target;
               state_in = S_XC;
            end else begin
               phase_in = PH_DECEL;
               dt_in = (mv_ff.elapsed > mv_ff.cruise_end_time)
                     ? mv_ff.elapsed - mv_ff.cruise_end_time : 32'd0;
               state_in = S_D0;
            end
         end
         S_D0: state_in = (phase_ff == PH_CRUISE) ? S_C1 : S_D1;
         S_C1: begin
            mv_in.profile_pos     = cruise_pos;
            mv_in.cruise_end_pos  = cruise_pos;
            mv_in.cruise_end_time = mv_ff.elapsed;
            xc_in    = cruise_pos;
            state_in = S_XC;
         end
         S_D1: begin
            msdt_in  = prod_ff[47:0];
            state_in = S_A0;
         end
         S_A0: state_in = S_A1;
         S_A1: begin
            hi_in    = prod_ff[63:48];
            state_in = S_A2;
         end
         S_A2: begin
            acc_in   = $signed({4'd0, prod_ff[47:0]});
            state_in = S_A3;
         end
         S_A3: begin
            term_in  = (full > SAT_CAP) ? SAT_CAP[62:0] : full[62:0];
            state_in = S_TERM;
         end
         S_TERM: begin
            if (phase_ff == PH_ACCEL) begin
               mv_in.profile_pos    = accel_pos;
               mv_in.accel_end_time = mv_ff.elapsed;
               mv_in.accel_end_pos  = accel_pos;
               xc_in    = accel_pos;
               state_in = S_XC;
            end else begin
               q_in     = decel_q;
               state_in = S_D2;
            end
         end
         S_D2: begin
            // a shrinking setpoint means the move is over
            if (decel_pos < mv_ff.profile_pos) begin
               xc_in = mv_ff.abs_target;
            end else begin
               mv_in.profile_pos = decel_pos;
               xc_in = decel_pos;
            end
            state_in = S_XC;
         end
         S_XC: begin
            xs_in     = xs_w;
            err_in    = sat32(64'(xs_w) - 64'(len_d));
            orient_in = sat32(64'(inc_r) - 64'(inc_l));
            state_in  = S_E1;
         end
         S_E1: begin
            mv_in.dist_int = sat32(64'(mv_ff.dist_int) + 64'(err_ff));
            state_in = S_E2;
         end
         S_E2: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = prod_ff[63:0];
            div_cmd.divisor  = mv_ff.abs_target[30:0];
            state_in = S_E3;
         end
         S_E3: begin
            acc_in   = prod_ff[51:0];
            state_in = S_E4;
         end
         S_E4: begin
            acc_in   = acc_ff + prod_ff[51:0];
            state_in = S_E5;
         end
         S_E5: begin
            cdist_in = acc_ff - prod_ff[51:0];
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (!div_busy) begin
               oerr_in  = sat32(64'(theta) - 64'(orient_ff));
               state_in = S_O1;
            end
         end
         S_O1: begin
            mv_in.orient_int = sat32(64'(mv_ff.orient_int) + 64'(oerr_ff));
            state_in = S_O2;
         end
         S_O2: begin
            acc_in   = prod_ff[51:0];
            state_in = S_O3;
         end
         S_O3: begin
            acc_in   = acc_ff + prod_ff[51:0];
            state_in = S_O4;
         end
         S_O4: begin
            corient_in = acc_ff - prod_ff[51:0];
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the previous result has been taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.left_pwm  = wl.pwm;
               rsp_in.right_pwm = wr.pwm;
               rsp_in.left_dir  = wl.pos;
               rsp_in.right_dir = wr.neg;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= CFG_RESET;
         mv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff   <= phase_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      dt_ff      <= dt_in;
      prod_ff    <= prod_in;
      hi_ff      <= hi_in;
      acc_ff     <= acc_in;
      msdt_ff    <= msdt_in;
      term_ff    <= term_in;
      q_ff       <= q_in;
      xc_ff      <= xc_in;
      xs_ff      <= xs_in;
      err_ff     <= err_in;
      orient_ff  <= orient_in;
      oerr_ff    <= oerr_in;
      cdist_ff   <= cdist_in;
      corient_ff <= corient_in;
   end

endmodule

`default_nettype wire

/* rtl/core/tpdp_checker.sv */
// Port-level checks of the trapezoid profile drive controller, bound to the top level.
// Depends on tpdp_pkg for the payload types.
`default_nettype none

module tpdp_props import tpdp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request still in work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a request in work");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == MODE_START) |=> !$rose(rsp_valid))
      else $error("start request produced a result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind trapezoid_profile_diff_drive_pi_unit tpdp_props u_tpdp_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* dv/tpdp_checker.sv */
// Port checker of the trapezoid profile drive controller: predicts wheel commands.
// Watches the req_, rsp_ and csr_ ports; depends on tpdp_pkg.
`timescale 1ns / 1ps

module tpdp_checker import tpdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam longint unsigned CAP = 64'd1 << 62;

   // registers
   longint unsigned cruise_speed, accel, min_pwm;
   longint kp_dist, ki_dist, kd_dist, ki_turn, kd_turn;
   // move state
   longint unsigned elapsed, accel_end_t, cruise_end_t;
   longint base_len, base_l, base_r, abs_target, angle_target;
   bit     move_pos;
   longint accel_dist, decel_start, prof_pos, accel_end_p, cruise_end_p;
   longint dist_int, orient_int;

   rsp_type drive_expect[$];

   assign pending = drive_expect.size();

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap32(longint v);
      logic signed [31:0] w;
      w = v[31:0];
      return longint'(w);
   endfunction

   function automatic longint unsigned eff_accel();
      return (accel == 0) ? 64'd1 : accel;
   endfunction

   function automatic longint unsigned accel_product(longint unsigned t);
      longint unsigned a, b;
      a = (t * t) >> TFRAC;
      b = eff_accel();
      if (a != 0 && b > CAP / a) return CAP;
      return a * b;
   endfunction

   function automatic longint next_setpoint();
      longint unsigned t, dt;
      longint p, q;
      t = elapsed;
      if (prof_pos < accel_dist) begin
         p = clamp32(longint'(accel_product(t) >> (TFRAC + 1)));
         prof_pos = p;
         accel_end_t = t;
         accel_end_p = p;
         return p;
      end
      if (prof_pos < decel_start) begin
         dt = (t > accel_end_t) ? t - accel_end_t : 0;
         p = clamp32(longint'((cruise_speed * dt) >> TFRAC) + accel_end_p);
         prof_pos = p;
         cruise_end_p = p;
         cruise_end_t = t;
         return p;
      end
      if (prof_pos >= abs_target) return abs_target;
      dt = (t > cruise_end_t) ? t - cruise_end_t : 0;
      q = (cruise_end_p <<< TFRAC) + longint'(cruise_speed * dt)
          - longint'(accel_product(dt) >> 1);
      p = (q >= 0) ? (q >>> TFRAC) : -((-q) >>> TFRAC);
      p = clamp32(p);
      if (p < prof_pos) return abs_target;
      prof_pos = p;
      return p;
   endfunction

   function automatic void wheel_out(longint cmd, output logic [9:0] pwm,
                                     output bit pos, output bit neg);
      longint unsigned mag;
      mag = longint'(cmd < 0 ? -cmd : cmd);
      if (mag < min_pwm * 256) begin
         cmd = 0;
         mag = 0;
      end
      mag = mag >> 8;
      pwm = (mag > 1023) ? PWM_MAX : mag[9:0];
      pos = cmd > 0;
      neg = cmd < 0;
   endfunction

   task automatic predict_drive(input req_type r);
      longint tl, len, inc_l, inc_r, spd_l, spd_r, robot_spd, xcons, err;
      longint orient, theta, oerr, cdist, corient;
      longint unsigned tsum;
      logic [9:0] lp, rp;
      bit lpos, lneg, rpos, rneg;
      rsp_type e;
      if (r.mode == MODE_START) begin
         tl = r.target_length;
         base_len = r.length_count;
         base_l = r.left_count;
         base_r = r.right_count;
         abs_target = (tl < 0) ? ((tl == -64'sd2147483648) ? 64'sd2147483647 : -tl) : tl;
         angle_target = r.target_angle;
         move_pos = tl > 0;
         accel_dist = longint'((cruise_speed * cruise_speed) / (2 * eff_accel()));
         decel_start = abs_target - accel_dist;
         elapsed = 0;
         prof_pos = 0;
         accel_end_t = 0;
         cruise_end_t = 0;
         accel_end_p = 0;
         cruise_end_p = 0;
         return;
      end
      tsum = elapsed + r.time_step;
      elapsed = (tsum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tsum;
      inc_l = wrap32(longint'(r.left_count) - base_l);
      inc_r = wrap32(longint'(r.right_count) - base_r);
      len = wrap32(longint'(r.length_count) - base_len);
      spd_l = r.left_speed;
      spd_r = r.right_speed;
      robot_spd = (spd_l + spd_r) / 2;
      xcons = next_setpoint();
      if (!move_pos) xcons = -xcons;
      err = clamp32(xcons - len);
      dist_int = clamp32(dist_int + err);
      cdist = err * kp_dist + dist_int * ki_dist - kd_dist * robot_spd;
      orient = clamp32(inc_r - inc_l);
      theta = (abs_target != 0) ? clamp32((angle_target * xcons) / abs_target) : 0;
      oerr = clamp32(theta - orient);
      orient_int = clamp32(orient_int + oerr);
      corient = oerr * 77 + orient_int * ki_turn - kd_turn * (spd_r - spd_l);
      wheel_out(cdist - corient, lp, lpos, lneg);
      wheel_out(cdist + corient, rp, rpos, rneg);
      e.left_pwm = lp;
      e.right_pwm = rp;
      e.left_dir = lpos;
      e.right_dir = rneg;
      drive_expect.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         cruise_speed = 1000; accel = 1000; kp_dist = 256;
         ki_dist = 0; kd_dist = 0; ki_turn = 0; kd_turn = 0; min_pwm = 0;
         elapsed = 0; accel_end_t = 0; cruise_end_t = 0;
         base_len = 0; base_l = 0; base_r = 0;
         abs_target = 0; angle_target = 0; move_pos = 0;
         accel_dist = 0; decel_start = 0; prof_pos = 0;
         accel_end_p = 0; cruise_end_p = 0;
         dist_int = 0; orient_int = 0;
         drive_expect.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_CRUISE_SPEED: cruise_speed = csr_wdata;
               REG_ACCEL:        accel = csr_wdata;
               REG_KP_DIST:      kp_dist = longint'(signed'(csr_wdata));
               REG_KI_DIST:      ki_dist = longint'(signed'(csr_wdata));
               REG_KD_DIST:      kd_dist = longint'(signed'(csr_wdata));
               REG_KI_TURN:      ki_turn = longint'(signed'(csr_wdata));
               REG_KD_TURN:      kd_turn = longint'(signed'(csr_wdata));
               REG_MIN_PWM:      min_pwm = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_drive(req_data);
         if (rsp_valid && rsp_ready) begin
            if (drive_expect.size() == 0) begin
               $error("unexpected result %p", rsp_data);
               fail_count++;
            end else begin
               e = drive_expect.pop_front();
               if (rsp_data.left_pwm !== e.left_pwm) begin
                  $error("left_pwm expected %0d actual %0d", e.left_pwm, rsp_data.left_pwm);
                  fail_count++;
               end
               if (rsp_data.right_pwm !== e.right_pwm) begin
                  $error("right_pwm expected %0d actual %0d", e.right_pwm, rsp_data.right_pwm);
                  fail_count++;
               end
               if (rsp_data.left_dir !== e.left_dir) begin
                  $error("left_dir expected %0d actual %0d", e.left_dir, rsp_data.left_dir);
                  fail_count++;
               end
               if (rsp_data.right_dir !== e.right_dir) begin
                  $error("right_dir expected %0d actual %0d", e.right_dir, rsp_data.right_dir);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

/* dv/tb.sv */
// Testbench top of the trapezoid profile drive controller: stimulus and verdict.
// Depends on tpdp_pkg, the block and tpdp_checker.
`timescale 1ns / 1ps

module tb import tpdp_pkg::*;;

   localparam int WATCHDOG = 20000;
   localparam int SETTLE   = 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   int          req_total;

   trapezoid_profile_diff_drive_pi_unit i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   tpdp_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // watchdog: cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result side: random stall stretches, some runs with no stall
   initial begin
      int n;
      rsp_ready <= 1'b0;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic send_request(input req_type r);
      int gap;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      req_total++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [15:0] ms, input logic [15:0] ac,
                            input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] kio,
                            input logic [15:0] kdo, input logic [9:0] mp);
      write_reg(REG_CRUISE_SPEED, ms);
      write_reg(REG_ACCEL, ac);
      write_reg(REG_KP_DIST, kp);
      write_reg(REG_KI_DIST, ki);
      write_reg(REG_KD_DIST, kd);
      write_reg(REG_KI_TURN, kio);
      write_reg(REG_KD_TURN, kdo);
      write_reg(REG_MIN_PWM, {6'd0, mp});
      @(posedge clock);
   endtask

   function automatic req_type start_req(input logic signed [31:0] tl,
                                         input logic signed [31:0] ta);
      req_type r;
      r = '0;
      r.mode = MODE_START;
      r.length_count = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000);
      r.left_count = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000);
      r.right_count = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000);
      r.left_speed = 16'($urandom);
      r.right_speed = 16'($urandom);
      r.time_step = 16'($urandom);
      r.target_length = tl;
      r.target_angle = ta;
      return r;
   endfunction

   function automatic req_type tick_req(input logic [15:0] ts);
      req_type r;
      r = '0;
      r.mode = MODE_TICK;
      if ($urandom_range(0, 4) == 0) begin
         r.length_count = $urandom;
         r.left_count = $urandom;
         r.right_count = $urandom;
         r.left_speed = 16'($urandom);
         r.right_speed = 16'($urandom);
      end else begin
         r.length_count = $urandom_range(0, 6000) - 3000;
         r.left_count = $urandom_range(0, 6000) - 3000;
         r.right_count = $urandom_range(0, 6000) - 3000;
         r.left_speed = 16'($urandom_range(0, 4000) - 2000);
         r.right_speed = 16'($urandom_range(0, 4000) - 2000);
      end
      r.time_step = ts;
      r.target_length = $urandom;
      r.target_angle = $urandom;
      return r;
   endfunction

   function automatic logic [15:0] rand_step();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'hFFFF;
      if (r == 1) return 16'd0;
      if (r < 6) return 16'($urandom_range(500, 8000));
      return 16'($urandom);
   endfunction

   task automatic random_moves(input int count);
      int done;
      int n;
      logic signed [31:0] tl;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) == 0) tl = $urandom;
         else tl = $urandom_range(0, 8000) - 4000;
         send_request(start_req(tl, $urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 400) - 200));
         n = $urandom_range(3, 30);
         repeat (n) send_request(tick_req(rand_step()));
         done += n + 1;
      end
   endtask

   task automatic random_regs();
      write_all(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 64) - 32),
                16'($urandom_range(0, 64) - 32), 16'($urandom_range(0, 64) - 32),
                16'($urandom_range(0, 64) - 32), 10'($urandom_range(0, 20)));
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_CRUISE_SPEED;
      csr_wdata <= '0;
      req_total = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks on the reset state, before any move
      send_request(tick_req(16'd0));
      send_request(tick_req(16'hFFFF));
      // zero length, most negative length, extremes of the other fields
      send_request(start_req(32'sd0, 32'sd100));
      send_request(tick_req(16'd1000));
      send_request(start_req(32'sh8000_0000, 32'sh7fff_ffff));
      repeat (3) send_request(tick_req(16'hFFFF));
      send_request(start_req(32'sh7fff_ffff, 32'sh8000_0000));
      repeat (3) send_request(tick_req(16'hFFFF));
      send_request(start_req(32'sd1200, -32'sd50));
      repeat (12) send_request(tick_req(16'd12000));
      drain();

      // extremes of the registers; zero accel acts as one
      write_all(16'hFFFF, 16'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                16'sh7fff, 10'd0);
      random_moves(60);
      // long run of ticks with the largest time step on a move of the largest length
      send_request(start_req(32'sh7fff_ffff, 32'sd7));
      repeat (20) send_request(tick_req(16'hFFFF));
      drain();
      write_all(16'd0, 16'hFFFF, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh8000, 10'd1023);
      random_moves(60);
      drain();
      write_all(16'd1000, 16'd1000, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd0);
      random_moves(120);
      drain();
      repeat (3) begin
         random_regs();
         random_moves(120);
         drain();
      end

      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
